// ===== hdl/first_fit_extent_allocator_unit_defines.svh =====
// Assertion macros shared by the checker files.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps
package ffa_pkg;

    // Sizes are rounded up to a multiple of this granule (a power of two).
    localparam int GRANULE_BYTES = 8;
    localparam logic [32:0] GRAN_ROUND = 33'(GRANULE_BYTES - 1);

    // Width of a cell position; covers tables of up to 1024 extents.
    localparam int POS_W = 11;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    localparam logic [31:0] BASE_RESET  = 32'h0100_0000;
    localparam logic [31:0] LIMIT_RESET = 32'h9000_0000;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOFIT   = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_OVERLAP = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    // Update command broadcast to every cell of the extent chain.
    typedef struct packed {
        logic             shl;     // cells at or above pos take their upper neighbor
        logic             shr;     // cells above pos take their lower neighbor
        logic [POS_W-1:0] pos;
        logic             wen;     // the cell at wpos takes wstart/wlen
        logic [POS_W-1:0] wpos;
        logic [31:0]      wstart;
        logic [31:0]      wlen;
    } cell_cmd_t;

    // Compare request broadcast to every cell.
    typedef struct packed {
        logic        eval;
        logic [31:0] addr;
        logic [32:0] n;
    } cell_eval_t;

endpackage

// ===== hdl/ffa_cell.sv =====
`timescale 1ns / 1ps
module ffa_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  ffa_pkg::cell_cmd_t  cmd,
    input  ffa_pkg::cell_eval_t ev,
    input  logic              in_use,
    input  logic [31:0]       lo_start,
    input  logic [31:0]       lo_len,
    input  logic [31:0]       hi_start,
    input  logic [31:0]       hi_len,
    output logic [31:0]       start,
    output logic [31:0]       len,
    output logic [32:0]       ext_end,
    output logic              fit,
    output logic              ge
);
    import ffa_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [31:0] start_reg, start_next;
    logic [31:0] len_reg, len_next;
    logic [32:0] end_reg;
    logic        fit_reg, ge_reg;

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (cmd.wen && cmd.wpos == MY_POS)
        begin
            start_next = cmd.wstart;
            len_next   = cmd.wlen;
        end
        else if (cmd.shl && MY_POS >= cmd.pos)
        begin
            start_next = hi_start;
            len_next   = hi_len;
        end
        else if (cmd.shr && MY_POS > cmd.pos)
        begin
            start_next = lo_start;
            len_next   = lo_len;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
        if (ev.eval)
        begin
            fit_reg <= in_use && ({1'b0, len_reg} >= ev.n);
            ge_reg  <= !in_use || (start_reg >= ev.addr);
            end_reg <= {1'b0, start_reg} + {1'b0, len_reg};
        end
    end

    assign start   = start_reg;
    assign len     = len_reg;
    assign ext_end = end_reg;
    assign fit     = fit_reg;
    assign ge      = ge_reg;

endmodule

// ===== hdl/first_fit_extent_allocator_unit.sv =====
`timescale 1ns / 1ps
// First-fit extent allocator with coalescing for one address region. Free extents are
// kept in address order in a chain of cells, one extent per cell, and every cell compares
// itself against a request in parallel; table updates (split, remove, insert, merge) are
// broadcast to all cells, which write one cell, shift by one place, or both. The first
// request after reset loads one extent spanning region_base to region_limit (none if the
// limit is not above the base). A request passes through these steps: the transfer (which
// also loads the region on the first request), compare in all cells, isolate the first
// matching cell, gather it and the cells beside the insertion point, then decide and
// update the chain. The next input transfer is taken in the cycle after the result is
// registered, so no request is taken while one is in flight, whatever the extent count.
// The result register holds a result until it is taken; a stalled output delays only the
// decide step of the following request. Configuration registers are written through
// cfg_wen/cfg_index/cfg_wdata and should be changed only while no request is in flight.
module first_fit_extent_allocator_unit #(
    parameter int MAX_EXTENTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_address [31:0], size_bytes [63:32]
    input  logic [ffa_pkg::IN_DATA_W-1:0]   s_tdata,
    // operation
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status [2:0], granted_address [34:3], free_total [66:35], zero [71:67]
    output logic [ffa_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_wen,
    input  logic                            cfg_index,
    input  logic [31:0]                     cfg_wdata
);
    import ffa_pkg::*;

    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_EXTENTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_PICK = 3'd2;
    localparam logic [2:0] S_GATH = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    // Control state.
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   free_reg, free_next;
    logic          loaded_reg, loaded_next;
    logic [31:0]   base_reg, limit_reg;
    logic          out_valid_reg, out_valid_next;

    // Request and intermediate payload.
    logic          op_reg;
    logic [31:0]   addr_reg;
    logic [32:0]   n_reg;
    logic          zero_reg;
    logic [MAX_EXTENTS-1:0] fit_oh_reg;
    logic [MAX_EXTENTS:0]   ge_oh_reg;
    logic          found_reg;
    logic [CW-1:0] sel_idx_reg, ins_idx_reg;
    logic [31:0]   sel_start_reg, sel_len_reg;
    logic          has_prev_reg, has_next_reg;
    logic [32:0]   prev_end_reg;
    logic [31:0]   prev_len_reg, next_start_reg, next_len_reg;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   granted_reg, granted_next;

    cell_cmd_t  cmd;
    cell_eval_t ev;

    logic [31:0] c_start [MAX_EXTENTS];
    logic [31:0] c_len   [MAX_EXTENTS];
    logic [32:0] c_end   [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] c_fit, c_ge, c_use;

    logic accept_in;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept_in = s_tvalid && s_tready;

    // The extent chain. Cells at or above the count hold nothing.
    for (genvar k = 0; k < MAX_EXTENTS; k++)
    begin : g_cell
        assign c_use[k] = (CW'(k) < count_reg);
        ffa_cell #(.IDX(k)) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .ev       (ev),
            .in_use   (c_use[k]),
            .lo_start (c_start[(k > 0) ? k - 1 : 0]),
            .lo_len   (c_len[(k > 0) ? k - 1 : 0]),
            .hi_start (c_start[(k < MAX_EXTENTS - 1) ? k + 1 : k]),
            .hi_len   (c_len[(k < MAX_EXTENTS - 1) ? k + 1 : k]),
            .start    (c_start[k]),
            .len      (c_len[k]),
            .ext_end  (c_end[k]),
            .fit      (c_fit[k]),
            .ge       (c_ge[k])
        );
    end

    assign ev.eval = (state_reg == S_EVAL);
    assign ev.addr = addr_reg;
    assign ev.n    = n_reg;

    // Lowest set bit of each compare vector. The insertion vector gets a sentinel above
    // the top cell, so a free past every stored extent lands at the count.
    logic [MAX_EXTENTS-1:0] fit_vec;
    logic [MAX_EXTENTS:0]   ge_vec;
    assign fit_vec = c_fit;
    assign ge_vec  = {1'b1, c_ge};

    // Gather the chosen cells through one-hot AND-OR selection.
    logic [CW-1:0] g_sel_idx, g_ins_idx;
    logic [31:0]   g_sel_start, g_sel_len, g_prev_len, g_next_start, g_next_len;
    logic [32:0]   g_prev_end;
    logic          g_has_prev, g_has_next;

    always_comb
    begin
        g_sel_idx    = '0;
        g_ins_idx    = '0;
        g_sel_start  = '0;
        g_sel_len    = '0;
        g_prev_len   = '0;
        g_next_start = '0;
        g_next_len   = '0;
        g_prev_end   = '0;
        g_has_prev   = 1'b0;
        g_has_next   = 1'b0;
        for (int k = 0; k < MAX_EXTENTS; k++)
        begin
            if (fit_oh_reg[k])
            begin
                g_sel_idx   = g_sel_idx | CW'(k);
                g_sel_start = g_sel_start | c_start[k];
                g_sel_len   = g_sel_len | c_len[k];
            end
            if (ge_oh_reg[k])
            begin
                g_ins_idx    = g_ins_idx | CW'(k);
                g_next_start = g_next_start | c_start[k];
                g_next_len   = g_next_len | c_len[k];
                g_has_next   = g_has_next | c_use[k];
            end
            if (ge_oh_reg[k + 1])
            begin
                g_prev_end = g_prev_end | c_end[k];
                g_prev_len = g_prev_len | c_len[k];
                g_has_prev = 1'b1;
            end
        end
        if (ge_oh_reg[MAX_EXTENTS])
        begin
            g_ins_idx = g_ins_idx | FULL_COUNT;
        end
    end

    // Decision and chain update.
    logic [33:0] blk_end;
    logic        join_prev, join_next, out_busy;
    assign blk_end   = {2'b0, addr_reg} + {1'b0, n_reg};
    assign join_prev = has_prev_reg && (prev_end_reg == {1'b0, addr_reg});
    assign join_next = has_next_reg && (blk_end == {2'b0, next_start_reg});
    assign out_busy  = out_valid_reg && !m_tready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        loaded_next    = loaded_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_EVAL;
                    if (!loaded_reg)
                    begin
                        // The region is loaded as one extent on the first request, if the limit is above the base.
                        loaded_next = 1'b1;
                        cmd.wen     = 1'b1;
                        cmd.wpos    = '0;
                        cmd.wstart  = base_reg;
                        cmd.wlen    = limit_reg - base_reg;
                        if (limit_reg > base_reg)
                        begin
                            count_next = CW'(1);
                            free_next  = limit_reg - base_reg;
                        end
                        else
                        begin
                            count_next = '0;
                            free_next  = '0;
                        end
                    end
                end
            end
            S_EVAL:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = S_GATH;
            end
            S_GATH:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!out_busy)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    granted_next   = '0;
                    status_next    = ST_OK;
                    if (zero_reg)
                    begin
                        status_next = ST_ZERO;
                    end
                    else if (op_reg == OP_ALLOC)
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOFIT;
                        end
                        else
                        begin
                            granted_next = sel_start_reg;
                            free_next    = free_reg - n_reg[31:0];
                            if ({1'b0, sel_len_reg} == n_reg)
                            begin
                                // Exact fit: the extent leaves the table.
                                cmd.shl    = 1'b1;
                                cmd.pos    = POS_W'(sel_idx_reg);
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                cmd.wen    = 1'b1;
                                cmd.wpos   = POS_W'(sel_idx_reg);
                                cmd.wstart = sel_start_reg + n_reg[31:0];
                                cmd.wlen   = sel_len_reg - n_reg[31:0];
                            end
                        end
                    end
                    else if (addr_reg < base_reg || blk_end > {2'b0, limit_reg})
                    begin
                        status_next = ST_RANGE;
                    end
                    else if ((has_prev_reg && {1'b0, addr_reg} < prev_end_reg) ||
                             (has_next_reg && blk_end > {2'b0, next_start_reg}))
                    begin
                        status_next = ST_OVERLAP;
                    end
                    else if (join_prev)
                    begin
                        // Grow the previous extent, and absorb the next one when the
                        // freed block closes the gap. Its start is its end less its length.
                        free_next  = free_reg + n_reg[31:0];
                        cmd.wen    = 1'b1;
                        cmd.wpos   = POS_W'(ins_idx_reg - CW'(1));
                        cmd.wstart = prev_end_reg[31:0] - prev_len_reg;
                        cmd.wlen   = prev_len_reg + n_reg[31:0] +
                                     (join_next ? next_len_reg : 32'd0);
                        if (join_next)
                        begin
                            cmd.shl    = 1'b1;
                            cmd.pos    = POS_W'(ins_idx_reg);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else if (join_next)
                    begin
                        free_next  = free_reg + n_reg[31:0];
                        cmd.wen    = 1'b1;
                        cmd.wpos   = POS_W'(ins_idx_reg);
                        cmd.wstart = addr_reg;
                        cmd.wlen   = next_len_reg + n_reg[31:0];
                    end
                    else if (count_reg == FULL_COUNT)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        // Open a slot at the insertion point and fill it.
                        free_next  = free_reg + n_reg[31:0];
                        cmd.shr    = 1'b1;
                        cmd.pos    = POS_W'(ins_idx_reg);
                        cmd.wen    = 1'b1;
                        cmd.wpos   = POS_W'(ins_idx_reg);
                        cmd.wstart = addr_reg;
                        cmd.wlen   = n_reg[31:0];
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_reg      <= '0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            loaded_reg    <= loaded_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                if (cfg_index == REG_BASE)
                begin
                    base_reg <= cfg_wdata;
                end
                else
                begin
                    limit_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        if (accept_in)
        begin
            op_reg   <= s_tuser;
            addr_reg <= s_tdata[31:0];
            zero_reg <= (s_tdata[63:32] == 32'd0);
            n_reg    <= ({1'b0, s_tdata[63:32]} + GRAN_ROUND) & ~GRAN_ROUND;
        end
        if (state_reg == S_PICK)
        begin
            fit_oh_reg <= fit_vec & (~fit_vec + MAX_EXTENTS'(1));
            ge_oh_reg  <= ge_vec & (~ge_vec + (MAX_EXTENTS + 1)'(1));
            found_reg  <= |fit_vec;
        end
        if (state_reg == S_GATH)
        begin
            sel_idx_reg    <= g_sel_idx;
            ins_idx_reg    <= g_ins_idx;
            sel_start_reg  <= g_sel_start;
            sel_len_reg    <= g_sel_len;
            has_prev_reg   <= g_has_prev;
            has_next_reg   <= g_has_next;
            prev_end_reg   <= g_prev_end;
            prev_len_reg   <= g_prev_len;
            next_start_reg <= g_next_start;
            next_len_reg   <= g_next_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, free_reg, granted_reg, status_reg};

endmodule

// ===== hdl/ffa_checker.sv =====
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_unit_defines.svh"
module ffa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ffa_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ffa_pkg::*;

    logic s_xfer, m_hold, st_fail;
    assign s_xfer  = s_tvalid && s_tready;
    assign m_hold  = m_tvalid && !m_tready;
    assign st_fail = m_tdata[2:0] != ST_OK;

    // Stalled results keep their value.
    `FFA_ASSERT_NEXT(a_out_hold, m_hold, m_tvalid && $stable(m_tdata))
    // A request is worked on alone: no second transfer right after one.
    `FFA_ASSERT_NEXT(a_one_at_a_time, s_xfer, !s_tready)
    // Only defined status codes appear.
    `FFA_ASSERT_SAME(a_status_code, m_tvalid, m_tdata[2:0] <= ST_FULL)
    // A failed request grants nothing.
    `FFA_ASSERT_SAME(a_fail_no_grant, m_tvalid && st_fail, m_tdata[34:3] == 32'd0)

endmodule

bind first_fit_extent_allocator_unit ffa_checker u_ffa_checker (.*);
